### src/slp_pkg.sv
// shared constants, codes and types of the static loop partitioner
package slp_pkg;

  localparam int DW           = 64;
  localparam int TC_W         = 11;
  localparam int TID_W        = 10;
  localparam int THREAD_LIMIT = 1024;
  localparam int DIV_LAT      = DW + 2;
  localparam int MUL_LAT      = 2;

  // schedule kinds
  localparam logic [1:0] SCH_EVEN  = 2'd0;
  localparam logic [1:0] SCH_CHUNK = 2'd1;
  localparam logic [1:0] SCH_RSV2  = 2'd2;
  localparam logic [1:0] SCH_RSV3  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_ZERO_INC = 2'd2;

  // sideband that rides along the pipeline
  typedef struct packed {
    logic                 v;
    logic [1:0]           kind;
    logic [TID_W-1:0]     gtid;
    logic [TC_W-1:0]      nth;
    logic signed [DW-1:0] lo;
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] st;
    logic signed [DW-1:0] incr;
    logic signed [DW-1:0] chunk;
    logic signed [DW-1:0] trips;
    logic signed [DW-1:0] per;
    logic signed [DW-1:0] extra;
    logic signed [DW-1:0] r3;
    logic signed [DW-1:0] a_p;
    logic signed [DW-1:0] t;
    logic signed [DW-1:0] hb;
    logic signed [DW-1:0] hs;
    logic signed [DW-1:0] hpi;
    logic signed [DW-1:0] lo_n;
    logic                 few_trips;
    logic                 ltx;
    logic                 ltt;
  } sb_t;

endpackage

### src/slp_div.sv
// pipelined signed divider, one quotient bit per stage, truncating
module slp_div (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [slp_pkg::DW-1:0]  dvd_i,
  input  logic signed [slp_pkg::DW-1:0]  dvs_i,
  output logic signed [slp_pkg::DW-1:0]  quo_o,
  output logic signed [slp_pkg::DW-1:0]  rem_o
);

  localparam int N = slp_pkg::DW;

  logic [N-1:0] r_r  [0:N];
  logic [N-1:0] dq_r [0:N];
  logic [N-1:0] dv_r [0:N];
  logic         qn_r [0:N];
  logic         rn_r [0:N];
  logic [N+1:0] trial [1:N];
  logic signed [N-1:0] quo_r, rem_r;

  // trial subtract of each stage
  always_comb begin
    for (int k = 1; k <= N; k++) begin
      trial[k] = {1'b0, r_r[k-1], dq_r[k-1][N-1]} - {2'b00, dv_r[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes and signs
      dq_r[0] <= dvd_i[N-1] ? (~dvd_i + 1'b1) : dvd_i;
      dv_r[0] <= dvs_i[N-1] ? (~dvs_i + 1'b1) : dvs_i;
      r_r[0]  <= '0;
      qn_r[0] <= dvd_i[N-1] ^ dvs_i[N-1];
      rn_r[0] <= dvd_i[N-1];
      // restoring iterations
      for (int k = 1; k <= N; k++) begin
        dv_r[k] <= dv_r[k-1];
        qn_r[k] <= qn_r[k-1];
        rn_r[k] <= rn_r[k-1];
        if (!trial[k][N+1]) begin
          r_r[k]  <= trial[k][N-1:0];
          dq_r[k] <= {dq_r[k-1][N-2:0], 1'b1};
        end else begin
          r_r[k]  <= {r_r[k-1][N-2:0], dq_r[k-1][N-1]};
          dq_r[k] <= {dq_r[k-1][N-2:0], 1'b0};
        end
      end
      // sign fix
      quo_r <= qn_r[N] ? (~dq_r[N] + 1'b1) : dq_r[N];
      rem_r <= rn_r[N] ? (~r_r[N] + 1'b1) : r_r[N];
    end
  end

  assign quo_o = quo_r;
  assign rem_o = rem_r;

endmodule

### src/slp_mul.sv
// two-stage wrapping multiplier, low word of the product from 32-bit partials
module slp_mul (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [slp_pkg::DW-1:0]  a_i,
  input  logic signed [slp_pkg::DW-1:0]  b_i,
  output logic signed [slp_pkg::DW-1:0]  p_o
);

  localparam int H = slp_pkg::DW / 2;

  logic [2*H-1:0] ll_r;
  logic [H-1:0]   lh_r, hl_r;
  logic [2*H-1:0] lh_full, hl_full;
  logic signed [slp_pkg::DW-1:0] p_r;

  assign lh_full = a_i[H-1:0] * b_i[2*H-1:H];
  assign hl_full = a_i[2*H-1:H] * b_i[H-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products
      ll_r <= a_i[H-1:0] * b_i[H-1:0];
      lh_r <= lh_full[H-1:0];
      hl_r <= hl_full[H-1:0];
      // combine
      p_r  <= ll_r + {lh_r + hl_r, {H{1'b0}}};
    end
  end

  assign p_o = p_r;

endmodule

### src/static_loop_partitioner_top.sv
// top level of the static loop partitioner
// throughput: one beat per cycle; the three pipelined dividers set the depth
// a stalled result holds the whole pipeline until it is taken
// reset: synchronous active low, clears valid bits; thread count returns to 1
module static_loop_partitioner_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [10:0]  cfg_wr_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [335:0] in_tdata,  // thread_id, lower_in, upper_in, stride_in, step, chunk_size
  input  logic [1:0]   in_tuser,  // schedule_kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata, // lower_out, upper_out, stride_out, is_last
  output logic [1:0]   out_tuser  // status
);

  localparam int DW  = slp_pkg::DW;
  localparam int TW  = slp_pkg::TC_W;
  localparam int IW  = slp_pkg::TID_W;
  localparam int DL  = slp_pkg::DIV_LAT;
  localparam int ML  = slp_pkg::MUL_LAT;

  logic en;
  logic [TW-1:0] tc_r;

  slp_pkg::sb_t s0_r, s0_nxt, s1_r, s2_r, s3_r, s4_r, s5_r;
  slp_pkg::sb_t s1_nxt, s2_nxt, s3_nxt, s4_nxt, s5_nxt;
  slp_pkg::sb_t d1_r [0:DL-1];
  slp_pkg::sb_t d2_r [0:DL-1];
  slp_pkg::sb_t d3_r [0:DL-1];
  slp_pkg::sb_t m1_r [0:ML-1];
  slp_pkg::sb_t m2_r [0:ML-1];

  logic signed [DW-1:0] dv1_a, dv1_b, q1, r1, dv2_a, dv2_b, q2, r2, dv3_a, dv3_b, q3, r3;
  logic signed [DW-1:0] ma_a, ma_b, pa, mb, mc_a, mc_b, pc, pd;

  logic                 o_v_r, o_last_r;
  logic signed [DW-1:0] o_lo_r, o_hi_r, o_st_r;
  logic [1:0]           o_stat_r;
  logic                 o_last_nxt;
  logic signed [DW-1:0] o_lo_nxt, o_hi_nxt;
  logic [1:0]           o_stat_nxt;

  // stall: the whole pipeline moves when the result register is free
  assign en        = !o_v_r || out_tready;
  assign in_tready = en;

  // thread count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= TW'(1);
    end else if (cfg_wr_en) begin
      tc_r <= cfg_wr_data;
    end
  end

  // input beat unpack, thread count clamp, chunk clamp
  always_comb begin
    s0_nxt       = '0;
    s0_nxt.v     = in_tvalid;
    s0_nxt.kind  = in_tuser;
    s0_nxt.gtid  = in_tdata[IW-1:0];
    s0_nxt.lo    = in_tdata[IW+DW-1:IW];
    s0_nxt.hi    = in_tdata[IW+2*DW-1:IW+DW];
    s0_nxt.st    = in_tdata[IW+3*DW-1:IW+2*DW];
    s0_nxt.incr  = in_tdata[IW+4*DW-1:IW+3*DW];
    s0_nxt.chunk = in_tdata[IW+5*DW-1:IW+4*DW];
    if ($signed(s0_nxt.chunk) < $signed(DW'(1))) begin
      s0_nxt.chunk = DW'(1);
    end
    if (tc_r == '0) begin
      s0_nxt.nth = TW'(1);
    end else if (tc_r > TW'(slp_pkg::THREAD_LIMIT)) begin
      s0_nxt.nth = TW'(slp_pkg::THREAD_LIMIT);
    end else begin
      s0_nxt.nth = tc_r;
    end
  end

  // trip count division: span over increment magnitude
  always_comb begin
    if ($signed(s0_r.incr) > $signed(DW'(0))) begin
      dv1_a = s0_r.hi - s0_r.lo;
      dv1_b = s0_r.incr;
    end else begin
      dv1_a = s0_r.lo - s0_r.hi;
      dv1_b = -s0_r.incr;
    end
  end

  slp_div u_div1 (.clk(clk), .en(en), .dvd_i(dv1_a), .dvs_i(dv1_b), .quo_o(q1), .rem_o(r1));

  // per-thread share or chunk index division
  always_comb begin
    if (s1_r.kind == slp_pkg::SCH_EVEN) begin
      dv2_a = s1_r.trips;
      dv2_b = {{(DW-TW){1'b0}}, s1_r.nth};
    end else begin
      dv2_a = s1_r.trips - DW'(1);
      dv2_b = s1_r.chunk;
    end
  end

  slp_div u_div2 (.clk(clk), .en(en), .dvd_i(dv2_a), .dvs_i(dv2_b), .quo_o(q2), .rem_o(r2));

  // chunk index modulo thread count
  assign dv3_a = s2_r.per;
  assign dv3_b = {{(DW-TW){1'b0}}, s2_r.nth};

  slp_div u_div3 (.clk(clk), .en(en), .dvd_i(dv3_a), .dvs_i(dv3_b), .quo_o(q3), .rem_o(r3));

  // first multiply level
  always_comb begin
    if (s3_r.kind == slp_pkg::SCH_EVEN && s3_r.few_trips) begin
      ma_a = {{(DW-IW){1'b0}}, s3_r.gtid};
      ma_b = s3_r.incr;
    end else if (s3_r.kind == slp_pkg::SCH_EVEN) begin
      ma_a = {{(DW-IW){1'b0}}, s3_r.gtid};
      ma_b = s3_r.per;
    end else begin
      ma_a = s3_r.chunk;
      ma_b = s3_r.incr;
    end
  end

  slp_mul u_mul_a (.clk(clk), .en(en), .a_i(ma_a), .b_i(ma_b), .p_o(pa));
  slp_mul u_mul_b (.clk(clk), .en(en), .a_i(s3_r.per), .b_i(s3_r.incr), .p_o(mb));

  // second multiply level
  always_comb begin
    if (s4_r.kind == slp_pkg::SCH_EVEN) begin
      mc_a = s4_r.incr;
      mc_b = s4_r.t;
    end else begin
      mc_a = s4_r.a_p;
      mc_b = {{(DW-TW){1'b0}}, s4_r.nth};
    end
  end

  slp_mul u_mul_c (.clk(clk), .en(en), .a_i(mc_a), .b_i(mc_b), .p_o(pc));
  slp_mul u_mul_d (.clk(clk), .en(en), .a_i(s4_r.a_p),
                   .b_i({{(DW-IW){1'b0}}, s4_r.gtid}), .p_o(pd));

  // trip count
  always_comb begin
    s1_nxt       = d1_r[DL-1];
    s1_nxt.trips = q1 + DW'(1);
  end

  // share and remainder
  always_comb begin
    s2_nxt       = d2_r[DL-1];
    s2_nxt.per   = q2;
    s2_nxt.extra = r2;
  end

  // comparisons for the share formulas
  always_comb begin
    s3_nxt           = d3_r[DL-1];
    s3_nxt.r3        = r3;
    s3_nxt.few_trips = $signed(s3_nxt.trips) < $signed({{(DW-TW){1'b0}}, s3_nxt.nth});
    s3_nxt.ltx       = $signed({{(DW-IW){1'b0}}, s3_nxt.gtid}) < $signed(s3_nxt.extra);
    s3_nxt.ltt       = $signed({{(DW-IW){1'b0}}, s3_nxt.gtid}) < $signed(s3_nxt.trips);
  end

  // first products folded into sums
  always_comb begin
    s4_nxt     = m1_r[ML-1];
    s4_nxt.a_p = pa;
    s4_nxt.t   = pa + (m1_r[ML-1].ltx ? {{(DW-IW){1'b0}}, m1_r[ML-1].gtid}
                                      : m1_r[ML-1].extra);
    s4_nxt.hb  = mb - (m1_r[ML-1].ltx ? DW'(0) : m1_r[ML-1].incr);
    s4_nxt.hs  = pa - m1_r[ML-1].incr;
    s4_nxt.hpi = m1_r[ML-1].hi + m1_r[ML-1].incr;
  end

  // new lower bound and stride
  always_comb begin
    s5_nxt = m2_r[ML-1];
    if (m2_r[ML-1].kind == slp_pkg::SCH_EVEN && m2_r[ML-1].few_trips) begin
      s5_nxt.lo_n = m2_r[ML-1].lo + m2_r[ML-1].a_p;
    end else if (m2_r[ML-1].kind == slp_pkg::SCH_EVEN) begin
      s5_nxt.lo_n = m2_r[ML-1].lo + pc;
    end else begin
      s5_nxt.lo_n = m2_r[ML-1].lo + pd;
    end
    if (m2_r[ML-1].kind == slp_pkg::SCH_CHUNK && m2_r[ML-1].incr != '0) begin
      s5_nxt.st = pc;
    end
  end

  // pipeline registers and delay lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.v <= 1'b0;
      s1_r.v <= 1'b0;
      s2_r.v <= 1'b0;
      s3_r.v <= 1'b0;
      s4_r.v <= 1'b0;
      s5_r.v <= 1'b0;
      for (int i = 0; i < DL; i++) begin
        d1_r[i].v <= 1'b0;
        d2_r[i].v <= 1'b0;
        d3_r[i].v <= 1'b0;
      end
      for (int i = 0; i < ML; i++) begin
        m1_r[i].v <= 1'b0;
        m2_r[i].v <= 1'b0;
      end
    end else if (en) begin
      s0_r    <= s0_nxt;
      d1_r[0] <= s0_r;
      d2_r[0] <= s1_r;
      d3_r[0] <= s2_r;
      m1_r[0] <= s3_r;
      m2_r[0] <= s4_r;
      for (int i = 1; i < DL; i++) begin
        d1_r[i] <= d1_r[i-1];
        d2_r[i] <= d2_r[i-1];
        d3_r[i] <= d3_r[i-1];
      end
      for (int i = 1; i < ML; i++) begin
        m1_r[i] <= m1_r[i-1];
        m2_r[i] <= m2_r[i-1];
      end
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      s4_r <= s4_nxt;
      s5_r <= s5_nxt;
    end
  end

  // result selection
  always_comb begin
    o_lo_nxt   = s5_r.lo;
    o_hi_nxt   = s5_r.hi;
    o_last_nxt = 1'b0;
    o_stat_nxt = slp_pkg::ST_BAD_KIND;
    if (s5_r.incr == '0) begin
      o_stat_nxt = slp_pkg::ST_ZERO_INC;
    end else if (s5_r.kind == slp_pkg::SCH_EVEN) begin
      o_stat_nxt = slp_pkg::ST_OK;
      if (s5_r.few_trips) begin
        o_lo_nxt   = s5_r.ltt ? s5_r.lo_n : s5_r.hpi;
        o_hi_nxt   = s5_r.ltt ? s5_r.lo_n : s5_r.hi;
        o_last_nxt = {{(DW-IW){1'b0}}, s5_r.gtid} == (s5_r.trips - DW'(1));
      end else begin
        o_lo_nxt   = s5_r.lo_n;
        o_hi_nxt   = s5_r.lo_n + s5_r.hb;
        o_last_nxt = {1'b0, s5_r.gtid} == (s5_r.nth - TW'(1));
      end
    end else if (s5_r.kind == slp_pkg::SCH_CHUNK) begin
      o_stat_nxt = slp_pkg::ST_OK;
      o_lo_nxt   = s5_r.lo_n;
      o_hi_nxt   = s5_r.lo_n + s5_r.hs;
      o_last_nxt = {{(DW-IW){1'b0}}, s5_r.gtid} == s5_r.r3;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r    <= s5_r.v;
      o_lo_r   <= o_lo_nxt;
      o_hi_r   <= o_hi_nxt;
      o_st_r   <= s5_r.st;
      o_last_r <= o_last_nxt;
      o_stat_r <= o_stat_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = {7'b0, o_last_r, o_st_r, o_hi_r, o_lo_r};
  assign out_tuser  = o_stat_r;

  // an error status never flags the final iteration
  a_err_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != slp_pkg::ST_OK) |-> !out_tdata[3*DW])
    else $error("error status with last flag set");

  // the clamped thread count stays within range
  a_nth_range: assert property (@(posedge clk) disable iff (!rst_n)
    s0_r.v |-> (s0_r.nth != '0 && s0_r.nth <= TW'(slp_pkg::THREAD_LIMIT)))
    else $error("thread count out of range");

  // a stalled pipeline keeps its first stage
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && s0_r.v) |=> (s0_r.v && $stable(s0_r.lo)))
    else $error("first stage lost during stall");

endmodule
